// ===== design/assert_macros.svh =====
// assertion macros shared by the double-ended queue rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons)

`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/dq_pkg.sv =====
// package for the double-ended queue: widths, operation and status codes, cell commands
// no dependencies
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DQ_DEPTH = 16;
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_REAR  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_REAR   = 3'd3,
      FUNC_LIST       = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_REAR,
      CELL_SHIFT_LEFT,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type             cmd;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== design/dq_intf.sv =====
// request and response channel interfaces for the double-ended queue
// depends on dq_pkg
`timescale 1ns / 1ps

interface dq_req_if;
   import dq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] value_out;
   logic                     last;
   modport source (output valid, output status, output value_out, output last, input ready);
   modport sink (input valid, input status, input value_out, input last, output ready);
endinterface

// ===== design/dq_cell.sv =====
// one storage cell of the queue chain; position 0 holds the front word
// depends on dq_pkg
`timescale 1ns / 1ps

module dq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                             clock,
   input  dq_pkg::cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]                 count,
   input  logic signed [dq_pkg::DATA_W-1:0] left_data,
   input  logic signed [dq_pkg::DATA_W-1:0] right_data,
   input  logic signed [dq_pkg::DATA_W-1:0] head_data,
   output logic signed [dq_pkg::DATA_W-1:0] data_out
);
   import dq_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     at_rear;
   logic                     at_tail;

   assign at_rear = (count == CNT_W'(INDEX));
   assign at_tail = (count == CNT_W'(INDEX + 1));

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CELL_PUSH_FRONT: data_in = left_data;
         CELL_PUSH_REAR:  data_in = at_rear ? ctrl.value : data_ff;
         CELL_SHIFT_LEFT: data_in = right_data;
         CELL_ROTATE:     data_in = at_tail ? head_data : right_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== design/double_ended_queue_unit.sv =====
// double-ended queue: push, pop and listing over a chain of shifting cells
// push and pop results are registered, valid in the cycle after the request is taken;
//    a listing request enters the listing state, then each word is registered for output
// throughput: while the response side is free, one push or pop per cycle; a listing of n
//    words blocks new requests until its last word is sent, one word per free cycle
// reset: synchronous, active high; clears occupancy and control, word storage not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_ended_queue_unit #(
   parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_if,
   dq_rsp_if.source rsp_if
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     last_ff, last_in;

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic [IDX_W-1:0]         tail_idx;
   logic                     out_free;
   logic                     accept;
   logic                     full;
   logic                     empty;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         dq_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .left_data  ((gi == 0) ? ctrl.value : cell_data[(gi == 0) ? 0 : gi - 1]),
            .right_data (cell_data[(gi == DEPTH - 1) ? gi : gi + 1]),
            .head_data  (cell_data[0]),
            .data_out   (cell_data[gi])
         );
      end
   endgenerate

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_if.valid && req_if.ready;
   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      ctrl.cmd     = CELL_HOLD;
      ctrl.value   = req_if.value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.func) inside
                  FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
                     rsp_valid_in = 1'b1;
                     last_in      = 1'b1;
                     if (full) begin
                        status_in = STAT_FULL;
                        value_in  = '0;
                     end else begin
                        status_in = STAT_OK;
                        value_in  = req_if.value;
                        count_in  = count_ff + CNT_W'(1);
                        ctrl.cmd  = (req_if.func == FUNC_PUSH_FRONT) ?
                                    CELL_PUSH_FRONT : CELL_PUSH_REAR;
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_REAR: begin
                     rsp_valid_in = 1'b1;
                     last_in      = 1'b1;
                     if (empty) begin
                        status_in = STAT_EMPTY;
                        value_in  = '0;
                     end else begin
                        status_in = STAT_OK;
                        count_in  = count_ff - CNT_W'(1);
                        if (req_if.func == FUNC_POP_FRONT) begin
                           value_in = cell_data[0];
                           ctrl.cmd = CELL_SHIFT_LEFT;
                        end else begin
                           value_in = cell_data[tail_idx];
                        end
                     end
                  end
                  FUNC_LIST: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STAT_EMPTY;
                        value_in     = '0;
                        last_in      = 1'b1;
                     end else begin
                        state_in  = S_LIST;
                        remain_in = count_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               value_in     = cell_data[0];
               last_in      = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
               ctrl.cmd     = CELL_ROTATE;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.value_out = value_ff;
   assign rsp_if.last      = last_ff;

   `DQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `DQ_ASSERT_IMPL(a_list_remain, clock, reset, state_ff == S_LIST, (remain_ff != '0) && (remain_ff <= count_ff))
   `DQ_ASSERT_NEXT(a_list_count_stable, clock, reset, state_ff == S_LIST, $stable(count_ff))
   `DQ_ASSERT_IMPL(a_error_zero, clock, reset, rsp_valid_ff && (status_ff != STAT_OK), (value_ff == '0) && last_ff)

endmodule

// ===== test/tb_top.sv =====
// testbench for double_ended_queue_unit: directed and random push, pop and listing traffic
// checks every response against a local deque model; depends on dq_pkg, dq_intf and the rtl
`timescale 1ns / 1ps

module tb_top;
   import dq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] word;
      logic                     last;
   } dq_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dq_req_if req_bus ();
   dq_rsp_if rsp_bus ();

   double_ended_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [DATA_W-1:0] deque_word [DQ_DEPTH];
   int                       deque_front = 0;
   int                       deque_count = 0;
   dq_result_type            pending_results [$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          sender_gaps = 1'b1;
   int          rsp_stall_mode = 1;
   int          hold_request = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   logic [15:0] stall_pattern = '1;
   int          pattern_step = 0;

   task automatic expect_result(status_type st, logic signed [DATA_W-1:0] w, logic l);
      dq_result_type r;
      r.status = st;
      r.word   = w;
      r.last   = l;
      pending_results.push_back(r);
   endtask

   task automatic predict_deque_results(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value);
      int slot;
      case (func)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (deque_count >= DQ_DEPTH) begin
               expect_result(STAT_FULL, '0, 1'b1);
            end else begin
               if (func == FUNC_PUSH_FRONT) begin
                  deque_front = (deque_front + DQ_DEPTH - 1) % DQ_DEPTH;
                  slot = deque_front;
               end else begin
                  slot = (deque_front + deque_count) % DQ_DEPTH;
               end
               deque_word[slot] = value;
               deque_count++;
               expect_result(STAT_OK, value, 1'b1);
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR: begin
            if (deque_count == 0) begin
               expect_result(STAT_EMPTY, '0, 1'b1);
            end else if (func == FUNC_POP_FRONT) begin
               expect_result(STAT_OK, deque_word[deque_front], 1'b1);
               deque_front = (deque_front + 1) % DQ_DEPTH;
               deque_count--;
            end else begin
               slot = (deque_front + deque_count - 1) % DQ_DEPTH;
               expect_result(STAT_OK, deque_word[slot], 1'b1);
               deque_count--;
            end
         end
         FUNC_LIST: begin
            if (deque_count == 0) begin
               expect_result(STAT_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < deque_count; i++) begin
                  expect_result(STAT_OK, deque_word[(deque_front + i) % DQ_DEPTH],
                                i == deque_count - 1);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value);
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_deque_results(func, value);
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(11, 0))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] random_func(int push_pct, int list_pct);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 2) return FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
      if (roll < 2 + list_pct) return FUNC_LIST;
      if (roll < 2 + list_pct + push_pct) begin
         return $urandom_range(1, 0) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT;
      end
      return $urandom_range(1, 0) ? FUNC_POP_REAR : FUNC_POP_FRONT;
   endfunction

   task automatic check_result();
      dq_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected transaction status %0d value %0d last %0d", $time,
                  rsp_bus.status, rsp_bus.value_out, rsp_bus.last);
         error_count++;
      end else begin
         want = pending_results.pop_front();
         if (rsp_bus.status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time,
                     want.status, rsp_bus.status);
            error_count++;
         end
         if (rsp_bus.value_out !== want.word) begin
            $display("%0t: value_out mismatch expected %0d actual %0d", $time,
                     want.word, rsp_bus.value_out);
            error_count++;
         end
         if (rsp_bus.last !== want.last) begin
            $display("%0t: last mismatch expected %0d actual %0d", $time,
                     want.last, rsp_bus.last);
            error_count++;
         end
      end
   endtask

   // response side: check, then pick ready from hold, mode and pattern
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_result();
      end
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_mode == 0) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= stall_pattern[pattern_step];
      end
      pattern_step = (pattern_step + 1) % 16;
      if (pattern_step == 0) begin
         stall_pattern = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom | $urandom);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_empty_queue();
      send_item(FUNC_POP_FRONT, random_word());
      send_item(FUNC_POP_REAR, random_word());
      send_item(FUNC_LIST, random_word());
      send_item(FUNC_UNUSED_LO, random_word());
      send_item(FUNC_UNUSED_HI, random_word());
   endtask

   task automatic test_full_queue();
      logic signed [DATA_W-1:0] word;
      for (int i = 0; i < DQ_DEPTH; i++) begin
         case (i)
            0: word = 32'sh8000_0000;
            1: word = 32'sh7fff_ffff;
            2: word = '0;
            3: word = -1;
            default: word = $urandom;
         endcase
         send_item(i[0] ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT, word);
      end
      send_item(FUNC_PUSH_FRONT, random_word());
      send_item(FUNC_PUSH_REAR, random_word());
      send_item(FUNC_LIST, random_word());
      send_item(FUNC_POP_FRONT, random_word());
      send_item(FUNC_POP_REAR, random_word());
   endtask

   // responses blocked for a long stretch while requests, mostly pushes, keep coming
   task automatic test_long_hold();
      rsp_stall_mode = 0;
      hold_request++;
      for (int i = 0; i < 24; i++) begin
         send_item(random_func(70, 8), random_word());
      end
      rsp_stall_mode = 1;
   endtask

   task automatic test_random_traffic();
      int push_pct [6] = '{75, 20, 48, 75, 20, 45};
      for (int phase = 0; phase < 6; phase++) begin
         sender_gaps    = (phase != 2);
         rsp_stall_mode = (phase == 3) ? 0 : 1;
         for (int i = 0; i < 55; i++) begin
            send_item(random_func(push_pct[phase], 6), random_word());
         end
      end
      sender_gaps    = 1'b1;
      rsp_stall_mode = 1;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func  = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_full_queue();
      test_long_hold();
      test_random_traffic();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/dq_pkg.sv
design/dq_intf.sv
design/dq_cell.sv
design/double_ended_queue_unit.sv
test/tb_top.sv
